// ----- hdl/chinese_remainder_combine_macros.svh -----
// assertion macros for the congruence combiner
// no dependencies; included by the modules that check themselves
`ifndef CHINESE_REMAINDER_COMBINE_MACROS_SVH
`define CHINESE_REMAINDER_COMBINE_MACROS_SVH

// implication checked at every rising clock edge out of reset
`define CRC_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// implication whose consequent is due in the next cycle
`define CRC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- hdl/crc_pkg.sv -----
// shared types and constants of the congruence combiner
// no dependencies
package crc_pkg;

   typedef struct packed {
      logic signed [63:0] residue;
      logic [31:0]        modulus;
      logic               last_item;
   } req_type;

   typedef struct packed {
      logic [62:0] solution;
      logic [62:0] combined_modulus;
      logic [1:0]  status;
   } rsp_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOSOL = 2'd1;
   localparam logic [1:0] ST_OVF   = 2'd2;
   localparam logic [1:0] ST_RSVD  = 2'd3;

   localparam logic OP_DIV = 1'b0;
   localparam logic OP_MUL = 1'b1;

   localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic        start;
      logic        op;
      logic [63:0] opa;
      logic [63:0] opb;
   } cmd_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quo;
      logic [63:0] rem;
   } unit_out_type;

endpackage

// ----- hdl/chinese_remainder_combine.sv -----
// congruence combiner, top level: input handshake and result register
// depends on crc_pkg and crc_ctrl
//
// req channel: one word per congruence (residue, modulus, last_item).
// req_stall is high while a word is being merged; a word is taken when
// req_valid is high and req_stall low.
// rsp channel: one word per list, issued after the word marked last_item,
// holding the smallest nonnegative solution, the lcm and a status
// (solved, no solution, lcm overflow). Fault results carry zeros.
// Every word with a nonzero modulus runs, while the list holds no fault,
// through one bit-serial unit that divides or multiplies, one operation
// at a time. A word whose modulus divides or is divided by the running
// modulus needs only the residue reduction, the divisibility check and a
// residue compare; a full merge also runs the gcd and extended-gcd loops
// (at most about 46 steps each for 32-bit moduli).
// The result sits in an output register; while rsp_stall is high it holds
// and the result of the next list waits, with req_stall high, until it is taken.
// Reset clears the running residue to 0, modulus to 1 and status to solved.
module chinese_remainder_combine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  crc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output crc_pkg::rsp_type rsp_data
);

   logic             ctrl_idle, ctrl_push, out_free;
   crc_pkg::rsp_type ctrl_result;
   logic             rsp_valid_ff, rsp_valid_in;
   crc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !ctrl_idle;

   crc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_valid),
      .item       (req_data),
      .out_free   (out_free),
      .idle       (ctrl_idle),
      .push       (ctrl_push),
      .result     (ctrl_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctrl_push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = ctrl_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hdl/crc_arith.sv -----
// shared bit-serial unit: 64/64 unsigned divide or 64x32 shift-add multiply
// depends on crc_pkg
module crc_arith (
   input  logic                  clock,
   input  logic                  reset,
   input  crc_pkg::cmd_type      cmd,
   output crc_pkg::unit_out_type res
);

   localparam logic [6:0] DIV_STEPS = 7'd64;
   localparam logic [6:0] MUL_STEPS = 7'd32;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [6:0]  count_ff, count_in;
   logic        op_ff, op_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [64:0] add_x, add_y, sum;

   always_comb begin
      if (op_ff == crc_pkg::OP_DIV) begin
         add_x = {rem_ff, quo_ff[63]};
         add_y = ~{1'b0, den_ff};
      end else begin
         add_x = {1'b0, rem_ff};
         add_y = {1'b0, quo_ff};
      end
      sum = add_x + add_y + {64'd0, (op_ff == crc_pkg::OP_DIV)};
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      op_in    = op_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         op_in    = cmd.op;
         quo_in   = cmd.opa;
         rem_in   = 64'd0;
         den_in   = cmd.opb;
         count_in = (cmd.op == crc_pkg::OP_DIV) ? DIV_STEPS : MUL_STEPS;
      end else if (busy_ff) begin
         if (op_ff == crc_pkg::OP_DIV) begin
            if (!sum[64]) begin
               rem_in = sum[63:0];
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = add_x[63:0];
               quo_in = {quo_ff[62:0], 1'b0};
            end
         end else begin
            if (den_ff[0]) rem_in = sum[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
            den_in = {1'b0, den_ff[63:1]};
         end
         count_in = count_ff - 7'd1;
         if (count_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= 7'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      op_ff  <= op_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign res.busy = busy_ff;
   assign res.done = done_ff;
   assign res.quo  = quo_ff;
   assign res.rem  = rem_ff;

endmodule

// ----- hdl/crc_ctrl.sv -----
// sequencer and running state of the congruence combiner
// depends on crc_pkg, crc_arith and chinese_remainder_combine_macros.svh
`include "chinese_remainder_combine_macros.svh"
module crc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  crc_pkg::req_type item,
   input  logic             out_free,
   output logic             idle,
   output logic             push,
   output crc_pkg::rsp_type result
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_WAIT    = 5'd1;
   localparam logic [4:0] S_NORM    = 5'd2;
   localparam logic [4:0] S_DIVCHK  = 5'd3;
   localparam logic [4:0] S_AGREE   = 5'd4;
   localparam logic [4:0] S_GCD     = 5'd5;
   localparam logic [4:0] S_U1      = 5'd6;
   localparam logic [4:0] S_DIFFCHK = 5'd7;
   localparam logic [4:0] S_OVCHK   = 5'd8;
   localparam logic [4:0] S_DQ      = 5'd9;
   localparam logic [4:0] S_AG      = 5'd10;
   localparam logic [4:0] S_INV0    = 5'd11;
   localparam logic [4:0] S_EQ      = 5'd12;
   localparam logic [4:0] S_ES      = 5'd13;
   localparam logic [4:0] S_INVFIN  = 5'd14;
   localparam logic [4:0] S_X       = 5'd15;
   localparam logic [4:0] S_XM      = 5'd16;
   localparam logic [4:0] S_RES     = 5'd17;
   localparam logic [4:0] S_MOD     = 5'd18;
   localparam logic [4:0] S_FIN     = 5'd19;

   logic [4:0]  state_ff, state_in, ret_ff, ret_in;
   logic        last_ff, last_in, neg_ff, neg_in, dneg_ff, dneg_in;
   logic [31:0] m_ff, m_in;
   logic [62:0] r0_ff, r0_in, m0_ff, m0_in;
   logic [31:0] r1_ff, r1_in, m1_ff, m1_in, g_ff, g_in, u1_ff, u1_in;
   logic [63:0] qabs_ff, qabs_in;
   logic [31:0] dq_ff, dq_in, er0_ff, er0_in, er1_ff, er1_in;
   logic [63:0] es0_ff, es0_in, es1_ff, es1_in;
   logic [62:0] acc_r_ff, acc_r_in, acc_m_ff, acc_m_in;
   logic [1:0]  acc_st_ff, acc_st_in;

   crc_pkg::cmd_type      cmd;
   crc_pkg::unit_out_type u;

   logic [31:0] rem32, r1v, invv;
   logic [63:0] absr, diff, es0_fix;

   crc_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .res   (u)
   );

   assign rem32   = u.rem[31:0];
   assign absr    = item.residue[63] ? (64'd0 - item.residue) : item.residue;
   assign r1v     = (neg_ff && rem32 != 32'd0) ? (m_ff - rem32) : rem32;
   assign diff    = {32'd0, r1_ff} - {1'b0, r0_ff};
   assign es0_fix = es0_ff[63] ? (es0_ff + {32'd0, u1_ff}) : es0_ff;
   assign invv    = es0_fix[31:0];

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      last_in   = last_ff;
      neg_in    = neg_ff;
      dneg_in   = dneg_ff;
      m_in      = m_ff;
      r0_in     = r0_ff;
      m0_in     = m0_ff;
      r1_in     = r1_ff;
      m1_in     = m1_ff;
      g_in      = g_ff;
      u1_in     = u1_ff;
      qabs_in   = qabs_ff;
      dq_in     = dq_ff;
      er0_in    = er0_ff;
      er1_in    = er1_ff;
      es0_in    = es0_ff;
      es1_in    = es1_ff;
      acc_r_in  = acc_r_ff;
      acc_m_in  = acc_m_ff;
      acc_st_in = acc_st_ff;
      cmd.start = 1'b0;
      cmd.op    = crc_pkg::OP_DIV;
      cmd.opa   = 64'd0;
      cmd.opb   = 64'd1;
      push      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               last_in = item.last_item;
               neg_in  = item.residue[63];
               m_in    = item.modulus;
               if (acc_st_ff != crc_pkg::ST_OK) begin
                  state_in = S_FIN;
               end else if (item.modulus == 32'd0) begin
                  acc_st_in = crc_pkg::ST_NOSOL;
                  state_in  = S_FIN;
               end else begin
                  cmd.start = 1'b1;
                  cmd.opa   = absr;
                  cmd.opb   = {32'd0, item.modulus};
                  ret_in    = S_NORM;
                  state_in  = S_WAIT;
               end
            end
         end
         S_WAIT: begin
            if (u.done) state_in = ret_ff;
         end
         S_NORM: begin
            if (acc_m_ff < {31'd0, m_ff}) begin
               r0_in = {31'd0, r1v};
               m0_in = {31'd0, m_ff};
               r1_in = acc_r_ff[31:0];
               m1_in = acc_m_ff[31:0];
            end else begin
               r0_in = acc_r_ff;
               m0_in = acc_m_ff;
               r1_in = r1v;
               m1_in = m_ff;
            end
            cmd.start = 1'b1;
            cmd.opa   = {1'b0, m0_in};
            cmd.opb   = {32'd0, m1_in};
            ret_in    = S_DIVCHK;
            state_in  = S_WAIT;
         end
         S_DIVCHK: begin
            cmd.start = 1'b1;
            state_in  = S_WAIT;
            if (u.rem == 64'd0) begin
               cmd.opa = {1'b0, r0_ff};
               cmd.opb = {32'd0, m1_ff};
               ret_in  = S_AGREE;
            end else begin
               g_in    = rem32;
               cmd.opa = {32'd0, m1_ff};
               cmd.opb = u.rem;
               ret_in  = S_GCD;
            end
         end
         S_AGREE: begin
            if (u.rem != {32'd0, r1_ff}) begin
               acc_st_in = crc_pkg::ST_NOSOL;
            end else begin
               acc_r_in = r0_ff;
               acc_m_in = m0_ff;
            end
            state_in = S_FIN;
         end
         S_GCD: begin
            cmd.start = 1'b1;
            state_in  = S_WAIT;
            if (u.rem == 64'd0) begin
               cmd.opa = {32'd0, m1_ff};
               cmd.opb = {32'd0, g_ff};
               ret_in  = S_U1;
            end else begin
               g_in    = rem32;
               cmd.opa = {32'd0, g_ff};
               cmd.opb = u.rem;
               ret_in  = S_GCD;
            end
         end
         S_U1: begin
            u1_in     = u.quo[31:0];
            dneg_in   = diff[63];
            cmd.start = 1'b1;
            cmd.opa   = diff[63] ? (64'd0 - diff) : diff;
            cmd.opb   = {32'd0, g_ff};
            ret_in    = S_DIFFCHK;
            state_in  = S_WAIT;
         end
         S_DIFFCHK: begin
            if (u.rem != 64'd0) begin
               acc_st_in = crc_pkg::ST_NOSOL;
               state_in  = S_FIN;
            end else begin
               qabs_in   = u.quo;
               cmd.start = 1'b1;
               cmd.opa   = crc_pkg::MAX63;
               cmd.opb   = {32'd0, u1_ff};
               ret_in    = S_OVCHK;
               state_in  = S_WAIT;
            end
         end
         S_OVCHK: begin
            if ({1'b0, m0_ff} > u.quo) begin
               acc_st_in = crc_pkg::ST_OVF;
               state_in  = S_FIN;
            end else begin
               cmd.start = 1'b1;
               cmd.opa   = qabs_ff;
               cmd.opb   = {32'd0, u1_ff};
               ret_in    = S_DQ;
               state_in  = S_WAIT;
            end
         end
         S_DQ: begin
            dq_in     = (dneg_ff && rem32 != 32'd0) ? (u1_ff - rem32) : rem32;
            cmd.start = 1'b1;
            cmd.opa   = {1'b0, m0_ff};
            cmd.opb   = {32'd0, g_ff};
            ret_in    = S_AG;
            state_in  = S_WAIT;
         end
         S_AG: begin
            cmd.start = 1'b1;
            cmd.opa   = u.quo;
            cmd.opb   = {32'd0, u1_ff};
            ret_in    = S_INV0;
            state_in  = S_WAIT;
         end
         S_INV0: begin
            er0_in = u1_ff;
            er1_in = rem32;
            es0_in = 64'd0;
            es1_in = 64'd1;
            if (rem32 == 32'd0) begin
               state_in = S_INVFIN;
            end else begin
               cmd.start = 1'b1;
               cmd.opa   = {32'd0, u1_ff};
               cmd.opb   = u.rem;
               ret_in    = S_EQ;
               state_in  = S_WAIT;
            end
         end
         S_EQ: begin
            er0_in    = er1_ff;
            er1_in    = rem32;
            cmd.start = 1'b1;
            cmd.op    = crc_pkg::OP_MUL;
            cmd.opa   = es1_ff;
            cmd.opb   = u.quo;
            ret_in    = S_ES;
            state_in  = S_WAIT;
         end
         S_ES: begin
            es0_in = es1_ff;
            es1_in = es0_ff - u.rem;
            if (er1_ff == 32'd0) begin
               state_in = S_INVFIN;
            end else begin
               cmd.start = 1'b1;
               cmd.opa   = {32'd0, er0_ff};
               cmd.opb   = {32'd0, er1_ff};
               ret_in    = S_EQ;
               state_in  = S_WAIT;
            end
         end
         S_INVFIN: begin
            cmd.start = 1'b1;
            cmd.op    = crc_pkg::OP_MUL;
            cmd.opa   = {32'd0, dq_ff};
            cmd.opb   = {32'd0, invv};
            ret_in    = S_X;
            state_in  = S_WAIT;
         end
         S_X: begin
            cmd.start = 1'b1;
            cmd.opa   = u.rem;
            cmd.opb   = {32'd0, u1_ff};
            ret_in    = S_XM;
            state_in  = S_WAIT;
         end
         S_XM: begin
            cmd.start = 1'b1;
            cmd.op    = crc_pkg::OP_MUL;
            cmd.opa   = {1'b0, m0_ff};
            cmd.opb   = u.rem;
            ret_in    = S_RES;
            state_in  = S_WAIT;
         end
         S_RES: begin
            acc_r_in  = r0_ff + u.rem[62:0];
            cmd.start = 1'b1;
            cmd.op    = crc_pkg::OP_MUL;
            cmd.opa   = {1'b0, m0_ff};
            cmd.opb   = {32'd0, u1_ff};
            ret_in    = S_MOD;
            state_in  = S_WAIT;
         end
         S_MOD: begin
            acc_m_in = u.rem[62:0];
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               push      = 1'b1;
               acc_r_in  = 63'd0;
               acc_m_in  = 63'd1;
               acc_st_in = crc_pkg::ST_OK;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      result.status = acc_st_ff;
      if (acc_st_ff == crc_pkg::ST_OK) begin
         result.solution         = acc_r_ff;
         result.combined_modulus = acc_m_ff;
      end else begin
         result.solution         = 63'd0;
         result.combined_modulus = 63'd0;
      end
   end

   assign idle = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ret_ff    <= S_IDLE;
         acc_r_ff  <= 63'd0;
         acc_m_ff  <= 63'd1;
         acc_st_ff <= crc_pkg::ST_OK;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         acc_r_ff  <= acc_r_in;
         acc_m_ff  <= acc_m_in;
         acc_st_ff <= acc_st_in;
      end
      last_ff <= last_in;
      neg_ff  <= neg_in;
      dneg_ff <= dneg_in;
      m_ff    <= m_in;
      r0_ff   <= r0_in;
      m0_ff   <= m0_in;
      r1_ff   <= r1_in;
      m1_ff   <= m1_in;
      g_ff    <= g_in;
      u1_ff   <= u1_in;
      qabs_ff <= qabs_in;
      dq_ff   <= dq_in;
      er0_ff  <= er0_in;
      er1_ff  <= er1_in;
      es0_ff  <= es0_in;
      es1_ff  <= es1_in;
   end

   `CRC_ASSERT_IMPL(a_busy_in_wait, clock, reset, u.busy, state_ff == S_WAIT, "unit busy outside wait")
   `CRC_ASSERT_IMPL(a_push_last, clock, reset, push, last_ff && out_free, "push without last word")
   `CRC_ASSERT_NEXT(a_push_clears, clock, reset, push, idle && acc_st_ff == crc_pkg::ST_OK && acc_m_ff == 63'd1, "state not cleared after list")
   `CRC_ASSERT_IMPL(a_status_code, clock, reset, 1'b1, acc_st_ff != crc_pkg::ST_RSVD, "reserved status")

endmodule

// ----- tb/chinese_remainder_combine_tb.sv -----
// testbench for the congruence combiner: directed table, then random lists
// checked against a built-in merge predictor
// depends on crc_pkg and chinese_remainder_combine
module chinese_remainder_combine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned LIMIT63     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam int              CYCLE_LIMIT = 20_000_000;
   localparam int              DRAIN_WAIT  = 12_000;

   typedef struct {
      longint           residue;
      longint unsigned  modulus;
      bit               last_item;
      bit               fixed;
      crc_pkg::rsp_type known;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   crc_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   crc_pkg::rsp_type rsp_data;

   longint unsigned  acc_res, acc_mod;
   logic [1:0]       acc_st;
   crc_pkg::rsp_type pending_lists[$];
   stim_row_type     stim_table[$];
   int               sender_idle_pct, recv_idle_pct;
   int               mismatches, cycles, solved_cnt, nosol_cnt, ovf_cnt, words_sent;

   chinese_remainder_combine u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   function automatic void clear_congruence();
      acc_res = 0;
      acc_mod = 1;
      acc_st  = crc_pkg::ST_OK;
   endfunction

   function automatic void merge_congruence(longint r, longint unsigned m);
      longint unsigned r0, m0, r1, m1, g, u1, a, b, t, x, inv;
      longint          rr, diff, dq, e0, e1, s0, s1, q, tt;
      if (m == 0) begin
         acc_st = crc_pkg::ST_NOSOL;
         return;
      end
      rr = r % $signed(m);
      if (rr < 0) rr = rr + $signed(m);
      r1 = rr;
      m1 = m;
      r0 = acc_res;
      m0 = acc_mod;
      if (m0 < m1) begin
         t = r0; r0 = r1; r1 = t;
         t = m0; m0 = m1; m1 = t;
      end
      if (m0 % m1 == 0) begin
         if (r0 % m1 != r1) acc_st = crc_pkg::ST_NOSOL;
         else begin
            acc_res = r0;
            acc_mod = m0;
         end
         return;
      end
      a = m0;
      b = m1;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      g = a;
      u1 = m1 / g;
      diff = $signed(r1) - $signed(r0);
      if (diff % $signed(g) != 0) begin
         acc_st = crc_pkg::ST_NOSOL;
         return;
      end
      if (m0 > LIMIT63 / u1) begin
         acc_st = crc_pkg::ST_OVF;
         return;
      end
      dq = (diff / $signed(g)) % $signed(u1);
      if (dq < 0) dq = dq + $signed(u1);
      e0 = $signed(u1);
      e1 = $signed((m0 / g) % u1);
      s0 = 0;
      s1 = 1;
      while (e1 != 0) begin
         q  = e0 / e1;
         tt = e0 - q * e1;
         e0 = e1;
         e1 = tt;
         tt = s0 - q * s1;
         s0 = s1;
         s1 = tt;
      end
      s0 = s0 % $signed(u1);
      if (s0 < 0) s0 = s0 + $signed(u1);
      inv = s0;
      x = (longint'(dq) * inv) % u1;
      acc_res = r0 + x * m0;
      acc_mod = m0 * u1;
   endfunction

   function automatic bit predict_word(crc_pkg::req_type w, output crc_pkg::rsp_type res);
      res = '0;
      if (acc_st == crc_pkg::ST_OK) merge_congruence(w.residue, longint'(w.modulus));
      if (!w.last_item) return 0;
      if (acc_st == crc_pkg::ST_OK) begin
         res.solution         = acc_res[62:0];
         res.combined_modulus = acc_mod[62:0];
      end
      res.status = acc_st;
      clear_congruence();
      return 1;
   endfunction

   task automatic send_word(crc_pkg::req_type w, bit fixed, crc_pkg::rsp_type known);
      crc_pkg::rsp_type res;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      // stall only moves at a rising edge, so its value at the falling edge holds
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      words_sent++;
      if (predict_word(w, res)) pending_lists.push_back(fixed ? known : res);
   endtask

   task automatic add_row(longint r, longint unsigned m, bit last, bit fixed,
                          longint unsigned sol = 0, longint unsigned lcm = 0,
                          logic [1:0] st = crc_pkg::ST_OK);
      stim_row_type row;
      row.residue   = r;
      row.modulus   = m;
      row.last_item = last;
      row.fixed     = fixed;
      row.known     = '{solution: sol[62:0], combined_modulus: lcm[62:0], status: st};
      stim_table.push_back(row);
   endtask

   task automatic send_random_list();
      longint unsigned  secret, m, base;
      longint           r;
      int               len, sel;
      crc_pkg::req_type w;
      len    = $urandom_range(5, 1);
      secret = {$urandom, $urandom} & LIMIT63;
      for (int i = 0; i < len; i++) begin
         sel = $urandom_range(9);
         if (sel == 0)      m = $urandom;
         else if (sel < 3)  m = $urandom_range(65535, 1);
         else               m = $urandom_range(200, 1);
         if ($urandom_range(49) == 0) m = 0;
         base = (m == 0) ? 0 : secret % m;
         sel = $urandom_range(9);
         if (sel < 5)       r = base;
         else if (sel < 7)  r = $signed(base) - $signed(m);
         else if (sel < 8)  r = $signed(base) + $signed(m) * $urandom_range(1000);
         else               r = {$urandom, $urandom};
         w.residue   = r;
         w.modulus   = m[31:0];
         w.last_item = (i == len - 1);
         send_word(w, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_lists.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result word %p", rsp_data);
            end else begin
               crc_pkg::rsp_type want;
               want = pending_lists.pop_front();
               case (want.status)
                  crc_pkg::ST_OK:    solved_cnt++;
                  crc_pkg::ST_NOSOL: nosol_cnt++;
                  default:           ovf_cnt++;
               endcase
               if (rsp_data.solution !== want.solution ||
                   rsp_data.combined_modulus !== want.combined_modulus ||
                   rsp_data.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: sol %0d/%0d lcm %0d/%0d status %0d/%0d (exp/act)",
                              want.solution, rsp_data.solution, want.combined_modulus,
                              rsp_data.combined_modulus, want.status, rsp_data.status);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      crc_pkg::req_type w;
      clear_congruence();
      sender_idle_pct = 35;
      recv_idle_pct   = 49;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      add_row(5, 7, 1, 1, 5, 7, crc_pkg::ST_OK);
      add_row(-1, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, crc_pkg::ST_OK);
      add_row(64'sh8000_0000_0000_0000, 1, 1, 1, 0, 1, crc_pkg::ST_OK);
      add_row(64'sh7FFF_FFFF_FFFF_FFFF, 1, 1, 1, 0, 1, crc_pkg::ST_OK);
      add_row(3, 0, 1, 1, 0, 0, crc_pkg::ST_NOSOL);
      add_row(1, 4, 0, 0);
      add_row(2, 6, 1, 1, 0, 0, crc_pkg::ST_NOSOL);
      add_row(2, 3, 0, 0);
      add_row(3, 5, 1, 1, 8, 15, crc_pkg::ST_OK);
      add_row(5, 12, 0, 0);
      add_row(1, 4, 1, 1, 5, 12, crc_pkg::ST_OK);
      add_row(5, 12, 0, 0);
      add_row(2, 4, 1, 1, 0, 0, crc_pkg::ST_NOSOL);
      add_row(0, 32'hFFFF_FFFF, 0, 0);
      add_row(0, 32'hFFFF_FFFE, 1, 1, 0, 0, crc_pkg::ST_OVF);
      add_row(1, 0, 0, 0);
      add_row(1, 3, 0, 0);
      add_row(2, 5, 1, 1, 0, 0, crc_pkg::ST_NOSOL);
      add_row(-123456789, 1000003, 0, 0);
      add_row(64'sh7FFF_FFFF_FFFF_FFFF, 65536, 0, 0);
      add_row(777, 999999, 1, 0);
      add_row(-17, 32'h8000_0000, 0, 0);
      add_row(64'sh5555_AAAA_5555_AAAA, 32'h5555_5555, 1, 0);

      foreach (stim_table[i]) begin
         w.residue   = stim_table[i].residue;
         w.modulus   = stim_table[i].modulus[31:0];
         w.last_item = stim_table[i].last_item;
         send_word(w, stim_table[i].fixed, stim_table[i].known);
      end

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 49 : 0;
         recv_idle_pct   = (phase == 0) ? 49 : (phase == 1) ? 35 : 0;
         for (int n = words_sent + 42; words_sent < n; ) send_random_list();
      end
      req_valid <= 1'b0;

      while (pending_lists.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d words sent, lists: %0d solved, %0d no solution, %0d overflow",
               words_sent, solved_cnt, nosol_cnt, ovf_cnt);
      $display("%0d mismatches over %0d cycles", mismatches, cycles);
      if (mismatches == 0 && pending_lists.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
